// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int NUM_TASKS_DEF = 8;

   localparam int IDX_W     = 3;
   localparam int TIME8_W   = 8;
   localparam int NOW_W     = 16;
   localparam int SLICE_W   = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   // wide enough to hold any table depth in range for index checks
   localparam int IDX_CMP_W = 6;

   localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd2;
   localparam logic [NOW_W-1:0]   TIME_MAX      = 16'hFFFF;
   localparam logic [SLICE_W-1:0] SLICE_MAX     = 8'hFF;

   // request kind carried on req_tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic load;
      logic tick_start;
      logic rem_rd;
      logic run;
      logic scan_start;
      logic scan_step;
      logic retire;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic ring_empty;
      logic time_max;
      logic scan_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== hw/rtl/rrts_ctrl.sv =====
// Sequencer for the scheduler: steps one request through the datapath.
`timescale 1ns / 1ps

module rrts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tuser,
   output logic               req_tready,
   input  rrts_pkg::dp_sts_type sts,
   output rrts_pkg::dp_cmd_type cmd
);
   import rrts_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REM_RD = 6'b000010,
      ST_RUN    = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_RETIRE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.tick_start = 1'b1;
                  state_in = sts.ring_empty ? ST_RUN : ST_REM_RD;
               end
            end
         end
         ST_REM_RD: begin
            cmd.rem_rd = 1'b1;
            state_in   = ST_RUN;
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            // a saturated clock has no arrivals to look for
            if (sts.time_max) begin
               state_in = ST_RETIRE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            cmd.retire = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

// ===== hw/rtl/rrts_dp.sv =====
// Scheduler datapath: task tables, ready ring, time and slice counters, result register.
`timescale 1ns / 1ps

module rrts_dp #(
   parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rrts_pkg::dp_cmd_type              cmd,
   output rrts_pkg::dp_sts_type              sts,
   input  logic [rrts_pkg::IDX_W-1:0]        task_index,
   input  logic [rrts_pkg::TIME8_W-1:0]      arrival_time,
   input  logic [rrts_pkg::TIME8_W-1:0]      service_time,
   input  logic                              csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]      csr_wr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);
   import rrts_pkg::*;

   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_TASKS + 1);
   localparam logic [TW-1:0] LAST_SLOT = TW'(NUM_TASKS - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_TASKS);

   // memories
   logic [TIME8_W-1:0] arrival_mem [NUM_TASKS];
   logic [TIME8_W-1:0] rem_mem     [NUM_TASKS];
   logic [TW-1:0]      ring_mem    [NUM_TASKS];
   logic [NUM_TASKS-1:0] rem_vld_ff;

   logic [TIME8_W-1:0] arr_q, rem_q;
   logic               rem_vld_q;
   logic [TW-1:0]      ring_q;

   // control registers
   logic [TW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [NOW_W-1:0]   now_ff, now_in;
   logic [SLICE_W-1:0] quantum_ff;
   logic [CW-1:0]      scan_idx_ff;
   logic               scan_pend_ff;
   logic               rsp_valid_ff;

   // per-request payload registers
   logic [TW-1:0]      head_task_ff;
   logic [TW-1:0]      chk_idx_ff;
   logic               ran_ff, fin_ff;
   logic [NOW_W-1:0]   slot_time_ff;
   logic [IDX_W-1:0]   out_task_ff;
   logic               out_idle_ff, out_fin_ff;
   logic [NOW_W-1:0]   out_time_ff;

   logic [TW-1:0]      rd_addr, rem_wr_addr, load_addr, push_val;
   logic [TIME8_W-1:0] rem_wr_data, rem_cur, rem_dec;
   logic               rem_wr_en, idx_ok, push_en, pop_en, push_ok;
   logic               scan_issue, scan_hit, rotate;
   logic [SLICE_W-1:0] q_eff;

   assign idx_ok    = IDX_CMP_W'(task_index) < IDX_CMP_W'(NUM_TASKS);
   assign load_addr = TW'(task_index);
   assign rd_addr   = cmd.rem_rd ? ring_q : scan_idx_ff[TW-1:0];
   assign rem_cur   = rem_vld_q ? rem_q : '0;
   assign rem_dec   = rem_cur - {{(TIME8_W-1){1'b0}}, |rem_cur};
   assign q_eff     = (quantum_ff == '0) ? {{(SLICE_W-1){1'b0}}, 1'b1} : quantum_ff;

   assign scan_issue = cmd.scan_step && (scan_idx_ff != FULL_CNT);
   assign scan_hit   = cmd.scan_step && scan_pend_ff
                       && ({{(NOW_W-TIME8_W){1'b0}}, arr_q} == now_ff)
                       && (rem_cur != '0);
   assign rotate     = cmd.retire && ran_ff && !fin_ff && (slice_ff >= q_eff);

   always_comb begin
      rem_wr_en   = 1'b0;
      rem_wr_addr = load_addr;
      rem_wr_data = service_time;
      if (cmd.load && idx_ok) begin
         rem_wr_en = 1'b1;
      end else if (cmd.run && ran_ff) begin
         rem_wr_en   = 1'b1;
         rem_wr_addr = head_task_ff;
         rem_wr_data = rem_dec;
      end
   end

   // push sources never coincide: load, arrival scan and rotation sit in separate states
   always_comb begin
      push_en  = 1'b0;
      push_val = load_addr;
      if (cmd.load) begin
         push_en = idx_ok && (arrival_time == '0) && (service_time != '0);
      end else if (scan_hit) begin
         push_en  = 1'b1;
         push_val = chk_idx_ff;
      end else if (rotate) begin
         push_en  = 1'b1;
         push_val = head_task_ff;
      end
   end

   assign pop_en  = cmd.retire && ran_ff && (fin_ff || rotate) && (count_ff != '0);
   assign push_ok = push_en && ((count_ff != FULL_CNT) || pop_en);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop_en) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      if (push_ok) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      unique case ({push_ok, pop_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      slice_in = slice_ff;
      if (cmd.run && ran_ff && (slice_ff != SLICE_MAX)) begin
         slice_in = slice_ff + 1'b1;
      end else if (cmd.retire && ran_ff && (fin_ff || rotate)) begin
         slice_in = '0;
      end
   end

   assign now_in = (cmd.run && (now_ff != TIME_MAX)) ? now_ff + 1'b1 : now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         slice_ff     <= '0;
         now_ff       <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rem_vld_ff   <= '0;
         scan_idx_ff  <= '0;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         slice_ff <= slice_in;
         now_ff   <= now_in;
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         if (rem_wr_en) begin
            rem_vld_ff[rem_wr_addr] <= 1'b1;
         end
         if (cmd.scan_start) begin
            scan_idx_ff  <= '0;
            scan_pend_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            scan_pend_ff <= scan_issue;
            if (scan_issue) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // memory ports, read data registered
   always_ff @(posedge clock) begin
      if (cmd.load && idx_ok) begin
         arrival_mem[load_addr] <= arrival_time;
      end
      if (rem_wr_en) begin
         rem_mem[rem_wr_addr] <= rem_wr_data;
      end
      if (push_ok) begin
         ring_mem[tail_ff] <= push_val;
      end
      arr_q     <= arrival_mem[rd_addr];
      rem_q     <= rem_mem[rd_addr];
      rem_vld_q <= rem_vld_ff[rd_addr];
      ring_q    <= ring_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         slot_time_ff <= now_ff;
         ran_ff       <= (count_ff != '0);
      end
      if (cmd.rem_rd) begin
         head_task_ff <= ring_q;
      end
      if (cmd.run) begin
         fin_ff <= ran_ff && (rem_dec == '0);
      end
      if (scan_issue) begin
         chk_idx_ff <= scan_idx_ff[TW-1:0];
      end
      if (cmd.emit) begin
         out_task_ff <= ran_ff ? IDX_W'(head_task_ff) : '0;
         out_idle_ff <= !ran_ff;
         out_fin_ff  <= fin_ff;
         out_time_ff <= slot_time_ff;
      end
   end

   assign sts.ring_empty = (count_ff == '0);
   assign sts.time_max   = (now_ff == TIME_MAX);
   assign sts.scan_done  = (scan_idx_ff == FULL_CNT) && !scan_pend_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_idle_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W-1-NOW_W){1'b0}}, out_time_ff, out_fin_ff, out_task_ff};

endmodule

// ===== hw/rtl/round_robin_task_scheduler_top.sv =====
// Flow: a load is taken while idle; a tick passes through a remaining-service read (skipped
// with an empty queue), run, an arrival scan of every slot (skipped once the clock saturates),
// retire and done, registering its result once the output is free. Throughput: one request
// at a time; loads every cycle; a tick blocks until done, longer while rsp_tready is low.
// Reset: synchronous, active high; clears queue, counters, remaining-service valid bits,
// and sets the quantum to 2.
`timescale 1ns / 1ps

module round_robin_task_scheduler_top #(
   parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] task_index, [10:3] arrival_time, [18:11] service_time, [23:19] zero
   input  logic [rrts_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] slot_task, [3] task_finished, [19:4] slot_time, [23:20] zero
   output logic [rrts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] idle
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]      csr_wr_data
);
   import rrts_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   logic [IDX_W-1:0]   task_index;
   logic [TIME8_W-1:0] arrival_time, service_time;

   assign task_index   = req_tdata[IDX_W-1:0];
   assign arrival_time = req_tdata[IDX_W +: TIME8_W];
   assign service_time = req_tdata[IDX_W+TIME8_W +: TIME8_W];

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rrts_dp #(
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .task_index   (task_index),
      .arrival_time (arrival_time),
      .service_time (service_time),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
